// ----- sv/peak_hold_decay_tracker_assert.svh -----
// ----------------------------------------------------------------------------
// peak_hold_decay_tracker assertion macros
// Shared concurrent assertion forms, sampled on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PEAK_HOLD_DECAY_TRACKER_ASSERT_SVH
`define PEAK_HOLD_DECAY_TRACKER_ASSERT_SVH

// same-cycle implication
`define PHDT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("phdt: assertion failed");

// next-cycle implication
`define PHDT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("phdt: assertion failed");

`endif

// ----- sv/phdt_pkg.sv -----
// ----------------------------------------------------------------------------
// phdt_pkg
// Types, widths and constants shared by the peak hold / decay tracker.
// ----------------------------------------------------------------------------
package phdt_pkg;

  localparam int PHDT_MAX_CHANNELS = 256;

  localparam int CHAN_W     = 8;
  localparam int LEVEL_W    = 18;
  localparam int PEAK_W     = 17;
  localparam int TIME_W     = 24;
  localparam int CHCNT_W    = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [PEAK_W-1:0] ONE_Q16 = 17'h10000;

  localparam logic [CHCNT_W-1:0] RST_CHANNELS = 9'd256;
  localparam logic [TIME_W-1:0]  RST_HOLD     = 24'd500000;
  localparam logic [PEAK_W-1:0]  RST_DECAY    = 17'd62259;
  localparam logic [PEAK_W-1:0]  RST_THRESH   = 17'd655;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHANNELS = 2'd0,
    CFG_HOLD     = 2'd1,
    CFG_DECAY    = 2'd2,
    CFG_THRESH   = 2'd3
  } cfg_idx_t;

  // classified item as queued between front and back
  typedef struct packed {
    logic              is_query;
    logic              index_ok;
    logic [CHAN_W-1:0] chan;
    logic [PEAK_W-1:0] level;
    logic [TIME_W-1:0] elapsed;
  } phdt_cmd_t;

  // one per-channel store entry
  typedef struct packed {
    logic [PEAK_W-1:0] peak;
    logic [TIME_W-1:0] hold;
  } phdt_ent_t;

  // settings seen by the update engine
  typedef struct packed {
    logic [TIME_W-1:0] hold_time;
    logic [PEAK_W-1:0] decay;
    logic [PEAK_W-1:0] thresh;
  } phdt_cfg_t;

endpackage

// ----- sv/phdt_if.sv -----
// ----------------------------------------------------------------------------
// phdt_if
// Valid/ready channel interfaces for update/query beats and result beats.
// ----------------------------------------------------------------------------
interface phdt_in_if;
  import phdt_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic [CHAN_W-1:0]         channel;
  logic signed [LEVEL_W-1:0] level;
  logic [TIME_W-1:0]         elapsed;

  modport source (output valid, req_type, channel, level, elapsed, input ready);
  modport sink   (input valid, req_type, channel, level, elapsed, output ready);
endinterface

interface phdt_out_if;
  import phdt_pkg::*;
  logic              valid;
  logic              ready;
  logic [PEAK_W-1:0] peak;
  logic              visible;
  logic              index_ok;

  modport source (output valid, peak, visible, index_ok, input ready);
  modport sink   (input valid, peak, visible, index_ok, output ready);
endinterface

// ----- sv/phdt_front.sv -----
// ----------------------------------------------------------------------------
// phdt_front
// Accepts input beats, clamps the level, checks the index, pushes to queue.
// ----------------------------------------------------------------------------
module phdt_front #(
  parameter int MAX_CHANNELS = phdt_pkg::PHDT_MAX_CHANNELS
) (
  input  logic [phdt_pkg::CHCNT_W-1:0] channels_in_use,
  phdt_in_if.sink                      in_bus,
  input  logic                         q_full,
  output logic                         q_push,
  output phdt_pkg::phdt_cmd_t          q_cmd
);
  import phdt_pkg::*;

  logic [PEAK_W-1:0] level_clamped;
  logic              index_ok;

  assign in_bus.ready = !q_full;
  assign q_push       = in_bus.valid && !q_full;

  always_comb begin
    if (in_bus.level[LEVEL_W-1]) begin
      level_clamped = '0;
    end else if (in_bus.level[PEAK_W-1:0] > ONE_Q16) begin
      level_clamped = ONE_Q16;
    end else begin
      level_clamped = in_bus.level[PEAK_W-1:0];
    end
  end

  assign index_ok = ({1'b0, in_bus.channel} < channels_in_use) &&
                    (32'(in_bus.channel) < 32'(MAX_CHANNELS));

  always_comb begin
    q_cmd.is_query = in_bus.req_type;
    q_cmd.index_ok = index_ok;
    q_cmd.chan     = in_bus.channel;
    q_cmd.level    = level_clamped;
    q_cmd.elapsed  = in_bus.elapsed;
  end

endmodule

// ----- sv/phdt_queue.sv -----
// ----------------------------------------------------------------------------
// phdt_queue
// Short FIFO of classified items between the front and the update engine.
// ----------------------------------------------------------------------------
module phdt_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  phdt_pkg::phdt_cmd_t din,
  output logic                full,
  output logic                valid,
  output phdt_pkg::phdt_cmd_t dout,
  input  logic                pop
);
  import phdt_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  phdt_cmd_t       slot_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == CW'(QUEUE_DEPTH));
  assign valid = (cnt_r != '0);
  assign dout  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ----- sv/phdt_back.sv -----
// ----------------------------------------------------------------------------
// phdt_back
// Update engine: per-channel store read, hold/decay update with write-back
// forwarding, and the result register.
// ----------------------------------------------------------------------------
`include "peak_hold_decay_tracker_assert.svh"

module phdt_back #(
  parameter int MAX_CHANNELS = phdt_pkg::PHDT_MAX_CHANNELS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  phdt_pkg::phdt_cmd_t q_cmd,
  output logic                q_pop,
  input  phdt_pkg::phdt_cfg_t cfg,
  phdt_out_if.source          out_bus
);
  import phdt_pkg::*;

  localparam int DEPTH = (MAX_CHANNELS < (1 << CHAN_W)) ? MAX_CHANNELS : (1 << CHAN_W);
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  phdt_ent_t mem [DEPTH];
  logic [DEPTH-1:0] vld_r;

  phdt_ent_t   rd_ent_r;
  logic        rd_vld_r;
  logic        s2_v_r;
  phdt_cmd_t   s2_cmd_r;
  logic        fwd_hit_r;
  phdt_ent_t   fwd_ent_r;

  logic              out_v_r;
  logic [PEAK_W-1:0] out_peak_r;
  logic              out_vis_r;
  logic              out_ok_r;

  logic              s2_adv;
  logic              wr_en;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     s2_addr;
  phdt_ent_t         cur;
  phdt_ent_t         new_ent;
  logic [PEAK_W-1:0] fac;
  logic [2*PEAK_W-1:0] prod;

  assign s2_adv  = s2_v_r && (!out_v_r || out_bus.ready);
  assign q_pop   = q_valid && (!s2_v_r || s2_adv);
  assign rd_addr = q_cmd.chan[AW-1:0];
  assign s2_addr = s2_cmd_r.chan[AW-1:0];
  assign wr_en   = s2_adv && s2_cmd_r.index_ok && !s2_cmd_r.is_query;

  // the item ahead wrote this entry on the edge our read happened
  assign cur  = fwd_hit_r ? fwd_ent_r : (rd_vld_r ? rd_ent_r : '0);
  assign fac  = (cfg.decay > ONE_Q16) ? ONE_Q16 : cfg.decay;
  assign prod = {{PEAK_W{1'b0}}, cur.peak} * {{PEAK_W{1'b0}}, fac};

  always_comb begin
    new_ent = cur;
    if (!s2_cmd_r.is_query) begin
      if (s2_cmd_r.level >= cur.peak) begin
        new_ent.peak = s2_cmd_r.level;
        new_ent.hold = cfg.hold_time;
      end else if (cur.hold != '0) begin
        new_ent.hold = (s2_cmd_r.elapsed >= cur.hold) ? '0 : cur.hold - s2_cmd_r.elapsed;
      end else begin
        new_ent.peak = prod[PEAK_W+15:16];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s2_addr] <= new_ent;
    end
    if (q_pop) begin
      rd_ent_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      s2_v_r    <= 1'b0;
      fwd_hit_r <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[s2_addr] <= 1'b1;
      end
      if (q_pop) begin
        s2_v_r    <= 1'b1;
        fwd_hit_r <= wr_en && (s2_addr == rd_addr);
      end else if (s2_adv) begin
        s2_v_r <= 1'b0;
      end
      if (s2_adv) begin
        out_v_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s2_cmd_r  <= q_cmd;
      rd_vld_r  <= vld_r[rd_addr];
      fwd_ent_r <= new_ent;
    end
    if (s2_adv) begin
      out_ok_r   <= s2_cmd_r.index_ok;
      out_peak_r <= s2_cmd_r.index_ok ? new_ent.peak : '0;
      out_vis_r  <= s2_cmd_r.index_ok && (new_ent.peak > cfg.thresh);
    end
  end

  assign out_bus.valid    = out_v_r;
  assign out_bus.peak     = out_peak_r;
  assign out_bus.visible  = out_vis_r;
  assign out_bus.index_ok = out_ok_r;

  `PHDT_ASSERT_IMP(a_bad_index_zero, out_v_r && !out_ok_r, out_peak_r == '0 && !out_vis_r)
  `PHDT_ASSERT_IMP(a_peak_in_range, out_v_r, out_peak_r <= ONE_Q16 && (!out_vis_r || out_peak_r != '0))
  `PHDT_ASSERT_NXT(a_write_marks_valid, wr_en, vld_r[$past(s2_addr)])

endmodule

// ----- sv/peak_hold_decay_tracker.sv -----
// Per-channel peak meter with hold timer and multiplicative decay, Q1.16.
// Sustains one update or query beat per clock when the output is not stalled;
// a result passes through the queue slot, the store read, and the update
// into the result register, the queue slot being written on the accepting
// edge. The per-channel store is updated read-modify-write: its read is
// registered, and a write-back bypass covers a channel hit by consecutive beats.
// Store entries carry valid bits cleared by reset, so no clearing pass runs
// and the block takes beats right after reset.
// ----------------------------------------------------------------------------
// peak_hold_decay_tracker
// Top level: configuration registers, front classifier, queue, update engine.
// ----------------------------------------------------------------------------
module peak_hold_decay_tracker #(
  parameter int MAX_CHANNELS = phdt_pkg::PHDT_MAX_CHANNELS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  phdt_in_if.sink                         in_bus,
  phdt_out_if.source                      out_bus,
  input  logic                            cfg_we,
  input  logic [phdt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [phdt_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import phdt_pkg::*;

  logic [CHCNT_W-1:0] channels_r;
  logic [TIME_W-1:0]  hold_time_r;
  logic [PEAK_W-1:0]  decay_r;
  logic [PEAK_W-1:0]  thresh_r;

  phdt_cfg_t cfg;
  logic      q_push, q_full, q_valid, q_pop;
  phdt_cmd_t q_in, q_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channels_r  <= RST_CHANNELS;
      hold_time_r <= RST_HOLD;
      decay_r     <= RST_DECAY;
      thresh_r    <= RST_THRESH;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CHANNELS: channels_r  <= cfg_wdata[CHCNT_W-1:0];
        CFG_HOLD:     hold_time_r <= cfg_wdata[TIME_W-1:0];
        CFG_DECAY:    decay_r     <= cfg_wdata[PEAK_W-1:0];
        CFG_THRESH:   thresh_r    <= cfg_wdata[PEAK_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.hold_time = hold_time_r;
  assign cfg.decay     = decay_r;
  assign cfg.thresh    = thresh_r;

  phdt_front #(.MAX_CHANNELS(MAX_CHANNELS)) u_front (
    .channels_in_use (channels_r),
    .in_bus          (in_bus),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_cmd           (q_in)
  );

  phdt_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .valid (q_valid),
    .dout  (q_out),
    .pop   (q_pop)
  );

  phdt_back #(.MAX_CHANNELS(MAX_CHANNELS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_cmd   (q_out),
    .q_pop   (q_pop),
    .cfg     (cfg),
    .out_bus (out_bus)
  );

endmodule
